FILE: design/md5bh_pkg.sv
`default_nettype none

package md5bh_pkg;

  // Chaining word initial values.
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // Default depth of the word queue between front and back.
  localparam int unsigned QueueDepth = 8;

  // Last word position of a 16-word block.
  localparam logic [3:0] LastPos = 4'd15;

  // Last round of the compression.
  localparam logic [5:0] LastRound = 6'd63;

  // One word on its way from the front to the back.
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  pos;
    logic        emit;
  } entry_t;

  // Additive constant of each round.
  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount of each round, by phase and round within a group of four.
  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
      4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
      4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
      4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
      4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Buffer index of the message word used in each round, modulo 16.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0: idx = lo;
      2'd1: idx = (lo << 2) + lo + 4'd1;
      2'd2: idx = (lo << 1) + lo + 4'd5;
      2'd3: idx = (lo << 3) - lo;
      default: idx = lo;
    endcase
    return idx;
  endfunction

  // Rotate left of a 32-bit word.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

FILE: design/md5_block_hash_top.sv
// Path: the word closing the final block goes through the word queue into the
// block buffer, then the prefetch step, the rounds and the final step, which
// latches the digest once any earlier digest is taken. Block rate is set by the
// one-round-per-cycle compression unit plus the word-at-a-time buffer load.
// Reset: rst_ni is asynchronous, active low; it loads the MD5 initial chaining
// words, clears the word position and empties the word queue.
`default_nettype none

module md5_block_hash_top #(
  parameter int unsigned QueueDepth = md5bh_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] message_word_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_a_o,
  output logic [31:0]      digest_b_o,
  output logic [31:0]      digest_c_o,
  output logic [31:0]      digest_d_o
);

  md5bh_pkg::entry_t push_entry, pop_entry;
  logic              push_valid, push_ready, pop_valid, pop_ready;

  // Front: takes words and tags block position and digest request.
  md5bh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .last_word_i    (last_word_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_entry_o   (push_entry)
  );

  // Word queue lets the front keep taking words during compression.
  md5bh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Back: block buffer, compression rounds and digest register.
  md5bh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digest_a_o  (digest_a_o),
    .digest_b_o  (digest_b_o),
    .digest_c_o  (digest_c_o),
    .digest_d_o  (digest_d_o)
  );

endmodule

`default_nettype wire

FILE: design/md5bh_front.sv
`default_nettype none

module md5bh_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [31:0]       message_word_i,
  input  wire logic              last_word_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output md5bh_pkg::entry_t      push_entry_o
);

  logic [3:0] pos_q, pos_d;
  logic       accept;

  // A word is taken whenever the queue has room.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;

  // Tag each word with its block position; the last mark only counts when the
  // word closes a block.
  always_comb begin
    push_entry_o.word = message_word_i;
    push_entry_o.pos  = pos_q;
    push_entry_o.emit = last_word_i & (pos_q == md5bh_pkg::LastPos);
  end

  // Position wraps after sixteen words.
  assign pos_d = accept ? pos_q + 4'd1 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/md5bh_queue.sv
`default_nettype none

module md5bh_queue #(
  parameter int unsigned Depth = md5bh_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire md5bh_pkg::entry_t push_entry_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output md5bh_pkg::entry_t      pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  md5bh_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/md5bh_back.sv
`default_nettype none

module md5bh_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  input  wire md5bh_pkg::entry_t pop_entry_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            digest_a_o,
  output logic [31:0]            digest_b_o,
  output logic [31:0]            digest_c_o,
  output logic [31:0]            digest_d_o
);

  typedef enum logic [1:0] {StLoad, StPre, StRound, StFinal} state_e;

  state_e      state_q;
  logic [5:0]  rnd_q;
  logic        emit_q;
  logic        out_valid_q;
  logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;

  logic [31:0] blk_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, km_q;
  logic [31:0] dig_a_q, dig_b_q, dig_c_q, dig_d_q;

  logic [5:0]  rnd_next;
  logic [31:0] f_w, mix_w, b_new;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;
  logic        pop, out_free, final_done;

  assign pop_ready_o = (state_q == StLoad);
  assign pop         = pop_valid_i & pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign final_done  = (state_q == StFinal) && (!emit_q || out_free);

  // Round after the current one; also the first round while in the prefetch step.
  assign rnd_next = (state_q == StPre) ? 6'd0 : rnd_q + 6'd1;

  // Round function selected by phase.
  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f_w = (b_q & c_q) | (~b_q & d_q);
      2'd1: f_w = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f_w = b_q ^ c_q ^ d_q;
      2'd3: f_w = c_q ^ (b_q | ~d_q);
      default: f_w = '0;
    endcase
  end

  // One round: the constant plus message word comes prefetched from a register.
  assign mix_w = a_q + f_w + km_q;
  assign b_new = b_q + md5bh_pkg::rotl32(mix_w, md5bh_pkg::rot_amount(rnd_q));

  // Feed-forward into the chaining words.
  assign sum_a = ch_a_q + a_q;
  assign sum_b = ch_b_q + b_q;
  assign sum_c = ch_c_q + c_q;
  assign sum_d = ch_d_q + d_q;

  // Sequencer, chaining words and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      rnd_q       <= 6'd0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ch_a_q      <= md5bh_pkg::InitA;
      ch_b_q      <= md5bh_pkg::InitB;
      ch_c_q      <= md5bh_pkg::InitC;
      ch_d_q      <= md5bh_pkg::InitD;
    end else begin
      // Result valid rises when a digest is latched and falls once it is taken.
      if (final_done && emit_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (pop && pop_entry_i.pos == md5bh_pkg::LastPos) begin
            emit_q  <= pop_entry_i.emit;
            state_q <= StPre;
          end
        end
        StPre: begin
          rnd_q   <= 6'd0;
          state_q <= StRound;
        end
        StRound: begin
          rnd_q <= rnd_next;
          if (rnd_q == md5bh_pkg::LastRound) begin
            state_q <= StFinal;
          end
        end
        StFinal: begin
          if (final_done) begin
            state_q <= StLoad;
            if (emit_q) begin
              ch_a_q      <= md5bh_pkg::InitA;
              ch_b_q      <= md5bh_pkg::InitB;
              ch_c_q      <= md5bh_pkg::InitC;
              ch_d_q      <= md5bh_pkg::InitD;
            end else begin
              ch_a_q <= sum_a;
              ch_b_q <= sum_b;
              ch_c_q <= sum_c;
              ch_d_q <= sum_d;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Block buffer, working words, prefetched round addend and digest register.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      blk_q[pop_entry_i.pos] <= pop_entry_i.word;
      if (pop_entry_i.pos == md5bh_pkg::LastPos) begin
        a_q <= ch_a_q;
        b_q <= ch_b_q;
        c_q <= ch_c_q;
        d_q <= ch_d_q;
      end
    end
    if (state_q == StPre || state_q == StRound) begin
      km_q <= md5bh_pkg::round_const(rnd_next) + blk_q[md5bh_pkg::msg_index(rnd_next)];
    end
    if (state_q == StRound) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
    end
    if (final_done && emit_q) begin
      dig_a_q <= sum_a;
      dig_b_q <= sum_b;
      dig_c_q <= sum_c;
      dig_d_q <= sum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign digest_a_o  = dig_a_q;
  assign digest_b_o  = dig_b_q;
  assign digest_c_o  = dig_c_q;
  assign digest_d_o  = dig_d_q;

endmodule

`default_nettype wire

FILE: tb/sv/md5_block_hash_top_tb.sv
`default_nettype none

module md5_block_hash_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 1050;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit = 400000;

  // Four chaining words of one finished message.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  // Tracks the expected hash state word by word and holds the digests still owed.
  class md5_digest_board;
    logic [31:0] block_buf [16];
    logic [31:0] chain [4];
    int unsigned fill_pos;
    logic [31:0] round_add [64];
    int unsigned shift_by [16];
    digest_t pending_digests [$];
    int unsigned words_seen;
    int unsigned digests_predicted;
    int unsigned digests_checked;
    int unsigned mismatches;

    function new();
      round_add = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
      };
      shift_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      foreach (block_buf[i]) block_buf[i] = '0;
      load_initial();
      fill_pos = 0;
      words_seen = 0;
      digests_predicted = 0;
      digests_checked = 0;
      mismatches = 0;
    endfunction

    function void load_initial();
      chain[0] = md5bh_pkg::InitA;
      chain[1] = md5bh_pkg::InitB;
      chain[2] = md5bh_pkg::InitC;
      chain[3] = md5bh_pkg::InitD;
    endfunction

    // The shift amounts never reach zero or 32, so the plain two-sided form is safe.
    function logic [31:0] rol_word(logic [31:0] x, int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    // Standard 64-round compression of the buffered block into the chain.
    function void compress_block();
      logic [31:0] a, b, c, d, f, t, sum;
      int unsigned phase, idx;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int unsigned r = 0; r < 64; r++) begin
        phase = r / 16;
        case (phase)
          0: begin
            f = (b & c) | (~b & d);
            idx = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            idx = 5 * r + 1;
          end
          2: begin
            f = b ^ c ^ d;
            idx = 3 * r + 5;
          end
          default: begin
            f = c ^ (b | ~d);
            idx = 7 * r;
          end
        endcase
        idx = idx % 16;
        sum = a + f + round_add[r] + block_buf[idx];
        t = d;
        d = c;
        c = b;
        b = b + rol_word(sum, shift_by[phase * 4 + r % 4]);
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // An accepted word; a last mark only counts on the word that closes a block.
    function void note_word(logic [31:0] w, logic last);
      digest_t dg;
      words_seen++;
      block_buf[fill_pos] = w;
      if (fill_pos != 15) begin
        fill_pos++;
      end else begin
        fill_pos = 0;
        compress_block();
        if (last) begin
          dg.a = chain[0];
          dg.b = chain[1];
          dg.c = chain[2];
          dg.d = chain[3];
          pending_digests.push_back(dg);
          digests_predicted++;
          load_initial();
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Compare one accepted digest with the oldest one owed.
    task check_digest(digest_t got);
      digest_t want;
      if (pending_digests.size() == 0) begin
        report_mismatch($sformatf("digest %h %h %h %h with none expected",
                                  got.a, got.b, got.c, got.d));
      end else begin
        want = pending_digests.pop_front();
        digests_checked++;
        if (got.a !== want.a)
          report_mismatch($sformatf("digest %0d word a: got %h want %h",
                                    digests_checked, got.a, want.a));
        if (got.b !== want.b)
          report_mismatch($sformatf("digest %0d word b: got %h want %h",
                                    digests_checked, got.b, want.b));
        if (got.c !== want.c)
          report_mismatch($sformatf("digest %0d word c: got %h want %h",
                                    digests_checked, got.c, want.c));
        if (got.d !== want.d)
          report_mismatch($sformatf("digest %0d word d: got %h want %h",
                                    digests_checked, got.d, want.d));
      end
    endtask

    function int unsigned pending();
      return pending_digests.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] message_word_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_a_o;
  logic [31:0] digest_b_o;
  logic [31:0] digest_c_o;
  logic [31:0] digest_d_o;

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 79;
  int unsigned cycle_count = 0;
  int unsigned gen_pos = 0;

  md5_digest_board board = new();

  md5_block_hash_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_a_o     (digest_a_o),
    .digest_b_o     (digest_b_o),
    .digest_c_o     (digest_c_o),
    .digest_d_o     (digest_d_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d digests outstanding.",
               cycle_count, board.pending());
      $display("md5_block_hash_top regression: fail");
      $finish;
    end
  end

  // Digest receiver: check each accepted digest and pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_digest('{a: digest_a_o, b: digest_b_o, c: digest_c_o, d: digest_d_o});
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Present one word, with an optional random gap first, and hold it until accepted.
  task automatic send_word(input logic [31:0] w, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    message_word_i <= w;
    last_word_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(w, last);
    gen_pos = (gen_pos + 1) % 16;
  endtask

  // Message word content biased toward the edges of the range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned rand_sent;
    logic last;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a full block of extreme words, closed without a mark but with
    // stray marks mid-block, then half of the next block.
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    for (int i = 4; i < 15; i++)
      send_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000, (i == 9));
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h0000_0080, 1'b1);
    for (int i = 1; i < 8; i++)
      send_word((i % 2) ? 32'h0000_0000 : 32'hffff_ffff, (i == 5));

    // Random messages of one or more blocks, with occasional stray marks.
    rand_sent = 0;
    while (rand_sent < RandomWords || gen_pos != 0) begin
      if (rand_sent == RandomWords / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 22;
      end else if (rand_sent == (2 * RandomWords) / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (gen_pos == 15)
        last = (rand_sent >= RandomWords) || ($urandom_range(0, 99) < 55);
      else
        last = ($urandom_range(0, 99) < 6);
      send_word(pick_word(), last);
      rand_sent++;
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding digests, then watch for stray output.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d message words and checked %0d digests under three pacing phases,",
             board.words_seen, board.digests_checked);
    $display("including stray mid-block marks and multi-block messages; %0d mismatches.",
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("md5_block_hash_top regression: pass");
    end else begin
      $display("md5_block_hash_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/md5bh_pkg.sv
design/md5bh_front.sv
design/md5bh_queue.sv
design/md5bh_back.sv
design/md5_block_hash_top.sv
tb/sv/md5_block_hash_top_tb.sv
